>>> rtl/core/utce_pkg.sv
// ----------------------------------------------------------------------------
// utce_pkg
// Constants and the month table for the UTC calendar to epoch seconds block.
// ----------------------------------------------------------------------------
package utce_pkg;

  // Field widths of one request and one result.
  localparam int unsigned YEAR_W  = 8;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned HOUR_W  = 5;
  localparam int unsigned MIN_W   = 6;
  localparam int unsigned SEC_W   = 6;
  localparam int unsigned EPOCH_W = 32;

  // Packed widths on the stream buses, rounded up to whole bytes.
  localparam int unsigned IN_FIELDS_W = YEAR_W + MONTH_W + DAY_W + HOUR_W + MIN_W + SEC_W;
  localparam int unsigned IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;

  // Intermediate widths, sized to the largest reachable value of each stage.
  localparam int unsigned DAYS_W  = 16;  // days since the epoch
  localparam int unsigned HOURS_W = 21;  // hours since the epoch
  localparam int unsigned MINS_W  = 27;  // minutes since the epoch
  localparam int unsigned DBM_W   = 9;   // days before a month, up to 366

  // Year span, counted from 1900.
  localparam logic [YEAR_W-1:0] YEAR_MIN        = 8'd70;
  localparam logic [YEAR_W-1:0] YEAR_MAX        = 8'd205;
  // 2100 is the only century year in the span that is not a leap year.
  localparam logic [YEAR_W-1:0] YEAR_CENTURY_NL = 8'd200;
  // Years divisible by four after 1900 and below 1970, counted from 1900 (that is 69 / 4).
  localparam logic [5:0]        LEAPS_BEFORE_MIN = 6'd17;

  localparam int unsigned DAYS_PER_YEAR = 365;

  // Days before the start of a month; months past December count the whole year.
  function automatic logic [DBM_W-1:0] days_before_month(input logic leap,
                                                         input logic [MONTH_W-1:0] mon);
    logic [DBM_W-1:0] base;
    logic             after_feb;
    begin
      after_feb = 1'b1;
      case (mon)
        4'd0: begin
          base = 9'd0;
          after_feb = 1'b0;
        end
        4'd1: begin
          base = 9'd31;
          after_feb = 1'b0;
        end
        4'd2:    base = 9'd59;
        4'd3:    base = 9'd90;
        4'd4:    base = 9'd120;
        4'd5:    base = 9'd151;
        4'd6:    base = 9'd181;
        4'd7:    base = 9'd212;
        4'd8:    base = 9'd243;
        4'd9:    base = 9'd273;
        4'd10:   base = 9'd304;
        4'd11:   base = 9'd334;
        default: base = 9'd365;
      endcase
      days_before_month = base + {{(DBM_W-1){1'b0}}, leap & after_feb};
    end
  endfunction

endpackage

>>> rtl/core/utc_calendar_to_epoch_seconds_top.sv
// ----------------------------------------------------------------------------
// utc_calendar_to_epoch_seconds_top
// Converts a broken-down UTC date and time into seconds since 1970-01-01.
// ----------------------------------------------------------------------------
// A four-stage pipeline that accepts one request per clock unless an output
// stall has filled it. Each result is presented from stage four, in order,
// and is held there until the output side is ready. The first stage
// forms the day count from the year (365 days a year plus the leap days
// before it, with 2100 left out), the month table and the day of month; the
// next three stages each hold one constant multiply and add (days by 24 plus
// hours, by 60 plus minutes, by 60 plus seconds). The running totals carry
// one spare bit as a sign, because day zero of January 1970 starts from
// minus one day and the hours, minutes and seconds may or may not lift the
// total back to the epoch. Every stage carries its own valid bit and moves on
// whenever the stage behind it is empty or moving, so a stall on the output
// side fills the pipeline without losing or repeating a request, and the
// block keeps taking requests while a result waits, until every stage is
// full. A year outside 1970 to 2105, or a total that falls before the epoch,
// raises the error flag in tuser with zero seconds in tdata.
module utc_calendar_to_epoch_seconds_top (
  input  logic                            clk,
  input  logic                            rst_n,
  // Request channel.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // years_since_1900 [7:0], month_index [11:8], day_of_month [16:12],
  // hour_of_day [21:17], minute_of_hour [27:22], second_of_minute [33:28],
  // zeros [39:34].
  input  logic [utce_pkg::IN_TDATA_W-1:0] in_tdata,
  // Result channel.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // epoch_seconds [31:0].
  output logic [utce_pkg::EPOCH_W-1:0]    out_tdata,
  // range_error [0].
  output logic                            out_tuser
);
  import utce_pkg::*;

  // Unpacked request fields.
  logic [YEAR_W-1:0]  in_year;
  logic [MONTH_W-1:0] in_month;
  logic [DAY_W-1:0]   in_day;
  logic [HOUR_W-1:0]  in_hour;
  logic [MIN_W-1:0]   in_min;
  logic [SEC_W-1:0]   in_sec;

  assign in_year  = in_tdata[7:0];
  assign in_month = in_tdata[11:8];
  assign in_day   = in_tdata[16:12];
  assign in_hour  = in_tdata[21:17];
  assign in_min   = in_tdata[27:22];
  assign in_sec   = in_tdata[33:28];

  // Stage valid bits and advance conditions. A stage takes new data when it is
  // empty or when its contents move on in the same cycle.
  logic v1_r, v2_r, v3_r, v4_r;
  logic adv1, adv2, adv3, adv4;

  assign adv4      = !v4_r || out_tready;
  assign adv3      = !v3_r || adv4;
  assign adv2      = !v2_r || adv3;
  assign adv1      = !v1_r || adv2;
  assign in_tready = adv1;

  // Stage one: day count from the year, the month and the day of month.
  logic                    year_bad;
  logic                    is_leap;
  logic [YEAR_W-1:0]       year_off;
  logic [YEAR_W-1:0]       year_m1;
  logic [5:0]              leap_days;
  logic [DAYS_W:0]         year_days;
  logic [DAYS_W:0]         day_sum;
  logic [DAYS_W:0]         days_nxt;

  always_comb begin
    year_bad  = (in_year < YEAR_MIN) || (in_year > YEAR_MAX);
    is_leap   = (in_year[1:0] == 2'b00) && (in_year != YEAR_CENTURY_NL);
    year_off  = in_year - YEAR_MIN;
    year_m1   = in_year - 8'd1;
    // Leap years from 1970 up to the year before this one.
    leap_days = year_m1[7:2] - LEAPS_BEFORE_MIN
                - {5'd0, (in_year > YEAR_CENTURY_NL)};
    year_days = (DAYS_W+1)'(DAYS_PER_YEAR) * {{(DAYS_W+1-YEAR_W){1'b0}}, year_off};
    day_sum   = year_days
                + {{(DAYS_W+1-6){1'b0}}, leap_days}
                + {{(DAYS_W+1-DBM_W){1'b0}}, days_before_month(is_leap, in_month)}
                + {{(DAYS_W+1-DAY_W){1'b0}}, in_day};
    // Day zero of January 1970 gives minus one here; the top bit is its sign.
    days_nxt  = day_sum - (DAYS_W+1)'(1);
  end

  logic [DAYS_W:0]   s1_days_r;
  logic [HOUR_W-1:0] s1_hour_r;
  logic [MIN_W-1:0]  s1_min_r;
  logic [SEC_W-1:0]  s1_sec_r;
  logic              s1_err_r;

  // Stage two: hours since the epoch, with a sign bit on top.
  logic [HOURS_W:0]   s2_hours_nxt;
  logic [HOURS_W:0]   s2_hours_r;
  logic [MIN_W-1:0]   s2_min_r;
  logic [SEC_W-1:0]   s2_sec_r;
  logic               s2_err_r;

  assign s2_hours_nxt = {{(HOURS_W-DAYS_W){s1_days_r[DAYS_W]}}, s1_days_r}
                        * (HOURS_W+1)'(24)
                        + {{(HOURS_W+1-HOUR_W){1'b0}}, s1_hour_r};

  // Stage three: minutes since the epoch, with a sign bit on top.
  logic [MINS_W:0]   s3_mins_nxt;
  logic [MINS_W:0]   s3_mins_r;
  logic [SEC_W-1:0]  s3_sec_r;
  logic              s3_err_r;

  assign s3_mins_nxt = {{(MINS_W-HOURS_W){s2_hours_r[HOURS_W]}}, s2_hours_r}
                       * (MINS_W+1)'(60)
                       + {{(MINS_W+1-MIN_W){1'b0}}, s2_min_r};

  // Stage four: seconds since the epoch, forced to zero on an error or when
  // the total falls before the epoch.
  logic [EPOCH_W:0]   s4_secs_nxt;
  logic               s4_neg;
  logic [EPOCH_W-1:0] s4_secs_r;
  logic               s4_err_r;

  assign s4_secs_nxt = {{(EPOCH_W-MINS_W){s3_mins_r[MINS_W]}}, s3_mins_r}
                       * (EPOCH_W+1)'(60)
                       + {{(EPOCH_W+1-SEC_W){1'b0}}, s3_sec_r};
  assign s4_neg      = s4_secs_nxt[EPOCH_W];

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_tvalid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (adv4) v4_r <= v3_r;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_days_r <= days_nxt;
      s1_hour_r <= in_hour;
      s1_min_r  <= in_min;
      s1_sec_r  <= in_sec;
      s1_err_r  <= year_bad;
    end
    if (adv2) begin
      s2_hours_r <= s2_hours_nxt;
      s2_min_r   <= s1_min_r;
      s2_sec_r   <= s1_sec_r;
      s2_err_r   <= s1_err_r;
    end
    if (adv3) begin
      s3_mins_r <= s3_mins_nxt;
      s3_sec_r  <= s2_sec_r;
      s3_err_r  <= s2_err_r;
    end
    if (adv4) begin
      s4_secs_r <= (s3_err_r || s4_neg) ? '0 : s4_secs_nxt[EPOCH_W-1:0];
      s4_err_r  <= s3_err_r || s4_neg;
    end
  end

  assign out_tvalid = v4_r;
  assign out_tdata  = s4_secs_r;
  assign out_tuser  = s4_err_r;

endmodule

>>> test/utc_calendar_to_epoch_seconds_top_test.sv
// ----------------------------------------------------------------------------
// utc_calendar_to_epoch_seconds_top_test
// Self-checking bench for the UTC calendar to epoch seconds converter.
// ----------------------------------------------------------------------------
// Broken-down UTC times are sent on the request stream. Each accepted request
// is run through a behavioural model of the conversion here in the bench, and
// the predicted seconds and range flag are queued. Every result that leaves
// the block is compared with the oldest queued prediction. Directed cases
// cover the year span, the month table and leap rule, and the day and time
// edges. A long random run follows, with bursty requests and an output side
// that stalls on a pattern of its own, including one long hold-off that
// fills the pipeline and stalls the request side.
// ----------------------------------------------------------------------------
module utc_calendar_to_epoch_seconds_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import utce_pkg::*;

  // Cycles without any transfer on either side before the run is abandoned.
  // The longest legitimate quiet spell is the long output hold-off below.
  localparam int unsigned STALL_LIMIT = 2000;
  // Length of the long output hold-off, in cycles.
  localparam int unsigned LONG_HOLD   = 300;
  // Cycles allowed for stray results after the last expected one.
  localparam int unsigned DRAIN_WAIT  = 12;

  // One request, laid out so that the year sits in the lowest bits, as on the bus.
  typedef struct packed {
    logic [SEC_W-1:0]   second;
    logic [MIN_W-1:0]   minute;
    logic [HOUR_W-1:0]  hour;
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } calendar_req_t;

  // One predicted result, tagged with the number of its request.
  typedef struct {
    logic [EPOCH_W-1:0] seconds;
    logic               range_error;
    int unsigned        serial;
  } epoch_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [EPOCH_W-1:0]    out_tdata;
  logic                  out_tuser;

  // Predictions waiting for their result, oldest first.
  epoch_result_t pending_epochs[$];

  int unsigned error_count  = 0;
  int unsigned sent_count   = 0;
  int unsigned burst_left   = 0;
  bit          sender_gaps_on = 1'b1;
  // Raised by a test to ask the output side for one long hold-off.
  bit          hold_request = 1'b0;

  utc_calendar_to_epoch_seconds_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Behavioural model of the conversion.
  // --------------------------------------------------------------------------

  // Gregorian rule: every fourth year, except centuries not divisible by 400.
  function automatic bit leap_year(input int unsigned since_1900);
    int unsigned y;
    y = since_1900 + 1900;
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int unsigned month_length(input int unsigned m, input bit leap);
    case (m)
      1: begin
        return leap ? 29 : 28;
      end
      3, 5, 8, 10: return 30;
      default:     return 31;
    endcase
  endfunction

  // Seconds since the epoch, or the error flag with zero seconds when the
  // year is out of span or day zero of January 1970 lands before the epoch.
  function automatic epoch_result_t predict_epoch(input calendar_req_t req);
    epoch_result_t res;
    longint        total;
    int unsigned   y;
    int unsigned   m;
    int unsigned   months_passed;
    bit            leap;
    res.seconds     = '0;
    res.range_error = 1'b1;
    res.serial      = 0;
    if (req.year < YEAR_MIN || req.year > YEAR_MAX) begin
      return res;
    end
    total = 0;
    for (y = YEAR_MIN; y < req.year; y++) begin
      total += leap_year(y) ? 366 : 365;
    end
    // Month codes past December count as the whole year having passed.
    leap          = leap_year(req.year);
    months_passed = (req.month > 12) ? 12 : req.month;
    for (m = 0; m < months_passed; m++) begin
      total += month_length(m, leap);
    end
    // Day zero is one day before the first; nothing is range checked here.
    total += longint'(req.day) - 1;
    total = total * 24 + longint'(req.hour);
    total = total * 60 + longint'(req.minute);
    total = total * 60 + longint'(req.second);
    if (total < 0) begin
      return res;
    end
    res.seconds     = EPOCH_W'(total);
    res.range_error = 1'b0;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Request side.
  // --------------------------------------------------------------------------

  function automatic calendar_req_t make_req(input int unsigned year, input int unsigned month,
                                             input int unsigned day, input int unsigned hour,
                                             input int unsigned minute,
                                             input int unsigned second);
    calendar_req_t r;
    r.year   = YEAR_W'(year);
    r.month  = MONTH_W'(month);
    r.day    = DAY_W'(day);
    r.hour   = HOUR_W'(hour);
    r.minute = MIN_W'(minute);
    r.second = SEC_W'(second);
    return r;
  endfunction

  // Most random requests keep every field in its calendar range, with the year
  // edges favoured now and then; the rest take any bit pattern the fields allow.
  function automatic calendar_req_t random_request();
    calendar_req_t r;
    logic [63:0]   raw;
    int unsigned   pick;
    if ($urandom_range(0, 4) != 0) begin
      r = make_req($urandom_range(YEAR_MIN, YEAR_MAX), $urandom_range(0, 11),
                   $urandom_range(1, 31), $urandom_range(0, 23), $urandom_range(0, 59),
                   $urandom_range(0, 60));
      if ($urandom_range(0, 7) == 0) begin
        pick = $urandom_range(0, 3);
        case (pick)
          0:       r.year = YEAR_MIN - 8'd1;
          1:       r.year = YEAR_MIN;
          2:       r.year = YEAR_MAX;
          default: r.year = YEAR_MAX + 8'd1;
        endcase
      end
    end else begin
      raw = {$urandom, $urandom};
      r   = raw[IN_FIELDS_W-1:0];
    end
    return r;
  endfunction

  // Offers one request and waits for it to be taken. Between bursts of random
  // length the valid is dropped for a random gap, unless gaps are switched off.
  task automatic send_request(input calendar_req_t req);
    int unsigned   gap;
    epoch_result_t predicted;
    if (sender_gaps_on && burst_left == 0) begin
      gap        = $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (burst_left > 0) begin
      burst_left--;
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W - IN_FIELDS_W){1'b0}}, req};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted        = predict_epoch(req);
    predicted.serial = sent_count;
    pending_epochs.push_back(predicted);
    sent_count++;
  endtask

  // --------------------------------------------------------------------------
  // Result side.
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int unsigned serial,
                                 input logic [EPOCH_W-1:0] wanted,
                                 input logic [EPOCH_W-1:0] seen);
    $display("[%0t] MISMATCH request %0d %s: expected %0d, got %0d", $realtime, serial,
             what, wanted, seen);
    error_count++;
  endtask

  // The output ready follows one of three moods, each held for a random
  // stretch: always ready, a coin toss per cycle, or mostly stalled. A hold
  // request from a test overrides all of them with the long hold-off.
  int unsigned sink_mood = 0;
  int unsigned mood_left = 0;
  int unsigned hold_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = LONG_HOLD - 1;
      out_tready  <= 1'b0;
    end else begin
      if (mood_left == 0) begin
        sink_mood = $urandom_range(0, 2);
        mood_left = $urandom_range(20, 120);
      end else begin
        mood_left--;
      end
      case (sink_mood)
        0:       out_tready <= 1'b1;
        1:       out_tready <= 1'($urandom_range(0, 1));
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Each transferred result is matched with the oldest prediction.
  always @(posedge clk) begin
    epoch_result_t wanted;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_epochs.size() == 0) begin
        report_mismatch("result with no request pending", sent_count, '0, out_tdata);
      end else begin
        wanted = pending_epochs.pop_front();
        if (out_tdata !== wanted.seconds) begin
          report_mismatch("epoch_seconds", wanted.serial, wanted.seconds, out_tdata);
        end
        if (out_tuser !== wanted.range_error) begin
          report_mismatch("range_error", wanted.serial, EPOCH_W'(wanted.range_error),
                          EPOCH_W'(out_tuser));
        end
      end
    end
  end

  // Gives up when neither side has moved anything within the stall limit.
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[%0t] no transfer for %0d cycles", $realtime, STALL_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Years either side of the valid span, and the extremes of the year field.
  task automatic test_year_span();
    send_request(make_req(70, 0, 1, 0, 0, 0));
    send_request(make_req(69, 5, 15, 12, 30, 30));
    send_request(make_req(206, 0, 1, 0, 0, 0));
    send_request(make_req(0, 0, 0, 0, 0, 0));
    send_request(make_req(255, 15, 31, 31, 63, 63));
    send_request(make_req(205, 11, 31, 23, 59, 59));
    send_request(make_req(138, 0, 19, 3, 14, 7));
  endtask

  // Leap days in 1972 and 2000, the missing one in 2100, and month codes
  // past December that count the whole year.
  task automatic test_month_table();
    send_request(make_req(72, 1, 29, 0, 0, 0));
    send_request(make_req(72, 2, 1, 0, 0, 0));
    send_request(make_req(100, 1, 29, 12, 0, 0));
    send_request(make_req(200, 1, 29, 0, 0, 0));
    send_request(make_req(200, 2, 1, 0, 0, 0));
    send_request(make_req(100, 12, 1, 0, 0, 0));
    send_request(make_req(101, 13, 1, 0, 0, 0));
    send_request(make_req(102, 14, 2, 1, 1, 1));
    send_request(make_req(103, 15, 1, 0, 0, 0));
  endtask

  // Day zero, which in January 1970 may fall before the epoch, oversized
  // hours, minutes and seconds, the leap second, and the largest total.
  task automatic test_day_and_time_edges();
    send_request(make_req(70, 0, 0, 0, 0, 0));
    send_request(make_req(70, 0, 0, 23, 59, 59));
    send_request(make_req(70, 0, 0, 24, 0, 0));
    send_request(make_req(150, 5, 0, 10, 10, 60));
    send_request(make_req(70, 0, 1, 0, 0, 60));
    send_request(make_req(120, 6, 15, 31, 63, 63));
    send_request(make_req(205, 15, 31, 31, 63, 63));
  endtask

  // Random requests; bursts with gaps and gap-free stretches alternate.
  task automatic test_random_traffic(input int unsigned count);
    int unsigned n;
    for (n = 0; n < count; n++) begin
      if ($urandom_range(0, 59) == 0) begin
        sender_gaps_on = !sender_gaps_on;
      end
      send_request(random_request());
    end
    sender_gaps_on = 1'b1;
  endtask

  // The output side holds off for a long stretch while requests keep coming
  // back to back, so the pipeline fills and the request side must stall.
  task automatic test_output_hold();
    int unsigned n;
    sender_gaps_on = 1'b0;
    hold_request   = 1'b1;
    for (n = 0; n < 40; n++) begin
      send_request(random_request());
    end
    sender_gaps_on = 1'b1;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_year_span();
    test_month_table();
    test_day_and_time_edges();
    test_random_traffic(400);
    test_output_hold();
    test_random_traffic(400);

    in_tvalid <= 1'b0;
    // The watchdog bounds this wait should a result never appear.
    while (pending_epochs.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/utce_pkg.sv
rtl/core/utc_calendar_to_epoch_seconds_top.sv
test/utc_calendar_to_epoch_seconds_top_test.sv
